### rtl/pcpc_pkg.sv
// shared types, constants and register codes of the phase code pulse compressor
// no dependencies; imported by every rtl module of the block
package pcpc_pkg;

    // sample word layout: four 16-bit channels, main i lowest
    localparam int NUM_CH   = 4;
    localparam int SAMPLE_W = 16;
    localparam int TERM_W   = SAMPLE_W + 1;
    localparam int WORD_W   = NUM_CH * SAMPLE_W;

    // window depth default and adder tree group size
    localparam int MAX_TAPS_DEFAULT = 16;
    localparam int GROUP_SIZE       = 8;

    // configuration register widths
    localparam int LEN_CFG_W  = 5;
    localparam int SIGN_BITS  = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register index codes, taken from paddr[2]
    localparam logic REG_CODE_LENGTH = 1'b0;
    localparam logic REG_CODE_SIGNS  = 1'b1;

    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] chan_word_t;
    typedef logic [NUM_CH-1:0][TERM_W-1:0]   term_word_t;

    // per-cell control from the window sequencer
    typedef struct packed {
        logic shift;
        logic active;
        logic neg;
    } cell_ctrl_t;

endpackage

### rtl/pcpc_cell.sv
// one window cell: holds a sample word, hands it to the next cell on shift
// and presents its signed code term; depends on pcpc_pkg
module pcpc_cell (
    input  logic                 aclk,
    input  pcpc_pkg::cell_ctrl_t ctrl,
    input  pcpc_pkg::chan_word_t data_in,
    output pcpc_pkg::chan_word_t data_out,
    output pcpc_pkg::term_word_t term
);
    import pcpc_pkg::*;

    chan_word_t sample_reg;

    // sample storage, moves one cell down the chain per accepted word
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            sample_reg <= data_in;
        end
    end

    assign data_out = sample_reg;

    // weighted term: +sample, -sample or zero outside the code
    always_comb begin
        logic signed [TERM_W-1:0] sx;
        for (int c = 0; c < NUM_CH; c++) begin
            sx = TERM_W'($signed(sample_reg[c]));
            if (!ctrl.active) begin
                term[c] = '0;
            end else if (ctrl.neg) begin
                term[c] = -sx;
            end else begin
                term[c] = sx;
            end
        end
    end

endmodule

### rtl/pcpc_scaler.sv
// divides one correlation sum by the code length through a reciprocal multiply,
// truncating toward zero and wrapping to 16 bits; depends on pcpc_pkg
module pcpc_scaler #(
    parameter int SUM_W   = 21,
    parameter int RECIP_W = 25,
    parameter int SHIFT   = 24
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [SUM_W-1:0]             sum_in,
    input  logic        [RECIP_W-1:0]           recip,
    output logic        [pcpc_pkg::SAMPLE_W-1:0] result
);
    import pcpc_pkg::*;

    localparam int MAG_W  = SUM_W - 1;
    localparam int PROD_W = MAG_W + RECIP_W;

    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic [SAMPLE_W-1:0] quot;
    logic [SAMPLE_W-1:0] result_reg;

    // magnitude of the sum
    always_comb begin
        logic signed [SUM_W-1:0] absval;
        absval = sum_in[SUM_W-1] ? -sum_in : sum_in;
        mag = absval[MAG_W-1:0];
    end

    // multiply stage
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(mag) * PROD_W'(recip);
            neg_reg  <= sum_in[SUM_W-1];
        end
    end

    // shift back, restore sign, wrap
    assign quot = prod_reg[SHIFT +: SAMPLE_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= neg_reg ? -quot : quot;
        end
    end

    assign result = result_reg;

endmodule

### rtl/phase_code_pulse_compressor.sv
// top level of the phase code pulse compressor: cell chain window, registered
// adder tree, reciprocal scalers and apb registers; depends on pcpc_pkg,
// pcpc_cell and pcpc_scaler
//
//  channel  | ports             | word
//  ---------+-------------------+------------------------------------------
//  input    | s_tvalid/s_tready | s_tdata main_i, main_q, back_i, back_q;
//           |                   | s_tlast last_of_sequence
//  output   | m_tvalid/m_tready | m_tdata decoded main/back i/q; m_tlast
//           |                   | end_of_sequence
//  config   | apb psel/penable  | code_length at 0x0, code_signs at 0x4
//
// one word is taken per cycle while the output side keeps up; a result leaves
// through the cell chain, group sum, total, multiply and output registers.
// a word that does not fill the window yields no result.
// a stalled output word freezes the whole pipeline, including s_tready.
// reset clears the fill count, the pipeline valid bits and the registers
// (code_length 1, code_signs 0); window cells hold no reset value.
module phase_code_pulse_compressor #(
    parameter int MAX_TAPS = pcpc_pkg::MAX_TAPS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pcpc_pkg::WORD_W-1:0]       s_tdata,  // main_i, main_q, back_i, back_q
    input  logic                              s_tlast,  // last_of_sequence
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcpc_pkg::WORD_W-1:0]       m_tdata,  // main_i_out, main_q_out, back_i_out,
                                                        // back_q_out
    output logic                              m_tlast,  // end_of_sequence
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcpc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pcpc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pcpc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import pcpc_pkg::*;

    localparam int LEN_W      = $clog2(MAX_TAPS + 1);
    localparam int IDX_W      = $clog2(MAX_TAPS);
    localparam int SIGN_IDX_W = $clog2(SIGN_BITS);
    localparam int SUM_W      = TERM_W + $clog2(MAX_TAPS);
    localparam int MAG_W      = SUM_W - 1;
    localparam int SHIFT      = MAG_W + $clog2(MAX_TAPS);
    localparam int RECIP_W    = SHIFT + 1;
    localparam int NGRP       = (MAX_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;

    // registers
    logic [LEN_CFG_W-1:0] code_length_reg;
    logic [SIGN_BITS-1:0] code_signs_reg;
    logic                 cfg_wr;

    // handshake and pipeline control
    logic en;
    logic accept;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] fill_reg, fill_next, fill_inc;
    logic emit;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic l0_reg, l1_reg, l2_reg, l3_reg, l4_reg;

    // datapath
    cell_ctrl_t                         cell_ctrl [MAX_TAPS];
    chan_word_t                         cell_data [MAX_TAPS+1];
    term_word_t                         cell_term [MAX_TAPS];
    logic signed [SUM_W-1:0]            grp_sum [NGRP][NUM_CH];
    logic signed [SUM_W-1:0]            grp_reg [NGRP][NUM_CH];
    logic signed [SUM_W-1:0]            tot_sum [NUM_CH];
    logic signed [SUM_W-1:0]            tot_reg [NUM_CH];
    logic [RECIP_W-1:0]                 recip_tab [MAX_TAPS];
    logic [RECIP_W-1:0]                 recip;
    chan_word_t                         result;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_length_reg <= LEN_CFG_W'(1);
            code_signs_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CODE_LENGTH: code_length_reg <= pwdata[LEN_CFG_W-1:0];
                REG_CODE_SIGNS:  code_signs_reg  <= pwdata[SIGN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CODE_LENGTH: prdata = CFG_DATA_W'(code_length_reg);
            REG_CODE_SIGNS:  prdata = CFG_DATA_W'(code_signs_reg);
            default:         prdata = '0;
        endcase
    end

    // effective length: zero counts as one, clipped to the window depth
    always_comb begin
        int cl;
        cl = int'(code_length_reg);
        if (cl == 0) begin
            len = LEN_W'(1);
        end else if (cl > MAX_TAPS) begin
            len = LEN_W'(MAX_TAPS);
        end else begin
            len = LEN_W'(cl);
        end
    end

    // global advance: everything moves unless the output word is stuck
    assign en       = !v4_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    // fill count, saturating, cleared after a last word
    assign fill_inc  = (fill_reg == LEN_W'(MAX_TAPS)) ? fill_reg : fill_reg + LEN_W'(1);
    assign emit      = fill_inc >= len;
    assign fill_next = s_tlast ? '0 : fill_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

    // cell controls: cell j holds the word of age j, code tap len-1-j
    always_comb begin
        logic [LEN_W-1:0] tap;
        for (int j = 0; j < MAX_TAPS; j++) begin
            tap = len - LEN_W'(j) - LEN_W'(1);
            cell_ctrl[j].shift  = accept;
            cell_ctrl[j].active = LEN_W'(j) < len;
            cell_ctrl[j].neg    = (len != LEN_W'(1)) && (LEN_W'(j) < len) &&
                                  (int'(tap) < SIGN_BITS) &&
                                  code_signs_reg[SIGN_IDX_W'(tap)];
        end
    end

    // window chain
    assign cell_data[0] = s_tdata;

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        pcpc_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl[j]),
            .data_in  (cell_data[j]),
            .data_out (cell_data[j+1]),
            .term     (cell_term[j])
        );
    end

    // group sums over eight cells each
    always_comb begin
        logic signed [SUM_W-1:0] acc;
        for (int g = 0; g < NGRP; g++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                acc = '0;
                for (int k = 0; k < GROUP_SIZE; k++) begin
                    if (g * GROUP_SIZE + k < MAX_TAPS) begin
                        acc = acc + SUM_W'($signed(cell_term[g * GROUP_SIZE + k][c]));
                    end
                end
                grp_sum[g][c] = acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            grp_reg <= grp_sum;
        end
    end

    // total over the groups
    always_comb begin
        logic signed [SUM_W-1:0] acc;
        for (int c = 0; c < NUM_CH; c++) begin
            acc = '0;
            for (int g = 0; g < NGRP; g++) begin
                acc = acc + grp_reg[g][c];
            end
            tot_sum[c] = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tot_reg <= tot_sum;
        end
    end

    // reciprocal table, ceil(2^SHIFT / length)
    for (genvar d = 0; d < MAX_TAPS; d++) begin : g_recip
        localparam longint unsigned DIV = longint'(d + 1);
        localparam longint unsigned RV  = ((64'd1 << SHIFT) + DIV - 64'd1) / DIV;
        assign recip_tab[d] = RV[RECIP_W-1:0];
    end

    assign recip = recip_tab[IDX_W'(len - LEN_W'(1))];

    // per-channel division
    for (genvar c = 0; c < NUM_CH; c++) begin : g_scale
        pcpc_scaler #(
            .SUM_W   (SUM_W),
            .RECIP_W (RECIP_W),
            .SHIFT   (SHIFT)
        ) u_scaler (
            .aclk   (aclk),
            .en     (en),
            .sum_in (tot_reg[c]),
            .recip  (recip),
            .result (result[c])
        );
    end

    // valid and end-of-sequence tracking along the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= accept && emit;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l0_reg <= s_tlast;
            l1_reg <= l0_reg;
            l2_reg <= l1_reg;
            l3_reg <= l2_reg;
            l4_reg <= l3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = result;
    assign m_tlast  = l4_reg;

`ifndef SYNTHESIS
    // no word enters while the output word is stalled
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // fill count stays within the window depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_W'(MAX_TAPS))
        else $error("fill count beyond window depth");

    // a last word clears the fill count
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (fill_reg == '0))
        else $error("window not cleared after last word");

    // a plain word below saturation grows the fill by one
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast && (fill_reg != LEN_W'(MAX_TAPS)))
        |=> (fill_reg == $past(fill_reg) + LEN_W'(1)))
        else $error("fill count did not advance");
`endif

endmodule
